// File: design/i2a_pkg.sv
`timescale 1ns / 1ps
// Shared types, format codes and character constants for integer_to_ascii_digits.
// No dependencies; imported by i2a_ctrl, i2a_datapath and the top level.
package i2a_pkg;

    // Format codes on s_req_type
    localparam logic [2:0] FMT_SDEC = 3'd0;
    localparam logic [2:0] FMT_UDEC = 3'd1;
    localparam logic [2:0] FMT_HEX  = 3'd2;
    localparam logic [2:0] FMT_OCT  = 3'd3;
    localparam logic [2:0] FMT_BIN  = 3'd4;

    // ASCII constants
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_UPPER = 8'h41;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    // Reciprocal of ten: q = (x * RECIP10) >> RECIP10_SHIFT is exact for 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;
    localparam int          QUOT_W        = 64 - RECIP10_SHIFT;

    // Digit stack holds one entry per binary bit at most
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = STACK_AW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_dec;
        logic neg;
        logic push_done;
        logic last_pop;
        logic out_free;
    } sts_t;

    // Map a digit value 0..15 to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHR_ZERO + {4'b0, d};
        end else begin
            c = CHR_UPPER + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: design/integer_to_ascii_digits.sv
`timescale 1ns / 1ps
// Top level of integer_to_ascii_digits: number in, ASCII characters out.
// Depends on i2a_pkg, i2a_ctrl and i2a_datapath.
//
//   channel  direction  payload                          handshake
//   s_       in         req_type[2:0] value[31:0] top_bit[4:0]  s_valid / s_ready
//   m_       out        character[7:0] last              m_valid / m_ready
//
// Decimal extracts each digit with a reciprocal multiply (ST_MUL), then a
// remainder and push (ST_PUSH); hex, octal and binary need only the push.
// Each character then leaves through the output register at one per cycle
// while m_ready holds high.
// Reset is synchronous, active low, and returns the controller to idle.
// A stalled m_ready holds the output register and freezes emission.
module integer_to_ascii_digits (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_value,
    input  logic [4:0]  s_top_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last
);
    import i2a_pkg::*;

    cmd_t cmd;
    sts_t sts;

    i2a_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .sts        (sts),
        .cmd        (cmd)
    );

    i2a_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .s_top_bit   (s_top_bit),
        .cmd         (cmd),
        .sts         (sts),
        .m_character (m_character),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule

// File: design/i2a_datapath.sv
`timescale 1ns / 1ps
// Datapath for integer_to_ascii_digits: digit extraction, digit stack, output register.
// Depends on i2a_pkg; driven by commands from i2a_ctrl.
module i2a_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        s_req_type,
    input  logic [31:0]       s_value,
    input  logic [4:0]        s_top_bit,
    input  i2a_pkg::cmd_t     cmd,
    output i2a_pkg::sts_t     sts,
    output logic [7:0]        m_character,
    output logic              m_last,
    output logic              m_valid,
    input  logic              m_ready
);
    import i2a_pkg::*;

    logic [31:0]          val_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [2:0]           fmt_reg;
    logic                 neg_reg;
    logic [STACK_CW-1:0]  bits_left_reg;
    logic [STACK_CW-1:0]  sp_reg;
    logic [3:0]           stack_mem [STACK_DEPTH];
    logic [7:0]           char_reg;
    logic                 last_reg;
    logic                 valid_reg;

    logic [63:0]          prod;
    logic [31:0]          quot_ext;
    logic [31:0]          quot_x10;
    logic [31:0]          rem;
    logic [3:0]           digit;
    logic [31:0]          val_next;
    logic [STACK_CW-1:0]  sp_dec;
    logic                 neg_in;

    // Reciprocal multiply and remainder for decimal digits
    assign prod     = val_reg * RECIP10;
    assign quot_ext = {{(32-QUOT_W){1'b0}}, quot_reg};
    assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    assign rem      = val_reg - quot_x10;

    // Select digit and shifted value for the current format
    always_comb begin
        unique case (fmt_reg)
            FMT_HEX: begin
                digit    = val_reg[3:0];
                val_next = val_reg >> 4;
            end
            FMT_OCT: begin
                digit    = {1'b0, val_reg[2:0]};
                val_next = val_reg >> 3;
            end
            FMT_BIN: begin
                digit    = {3'b0, val_reg[0]};
                val_next = val_reg >> 1;
            end
            default: begin
                digit    = rem[3:0];
                val_next = quot_ext;
            end
        endcase
    end

    assign neg_in    = (s_req_type == FMT_SDEC) && s_value[31];
    assign sp_dec    = sp_reg - {{(STACK_CW-1){1'b0}}, 1'b1};

    // Status back to the controller
    assign sts.is_dec    = (fmt_reg == FMT_SDEC) || (fmt_reg == FMT_UDEC);
    assign sts.neg       = neg_reg;
    assign sts.push_done = (fmt_reg == FMT_BIN)
                           ? (bits_left_reg == {{(STACK_CW-1){1'b0}}, 1'b1})
                           : (val_next == 32'd0);
    assign sts.last_pop  = (sp_reg == {{(STACK_CW-1){1'b0}}, 1'b1});
    assign sts.out_free  = !valid_reg || m_ready;

    // Latch a new number, then advance extraction one step per command
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fmt_reg       <= s_req_type;
            neg_reg       <= neg_in;
            val_reg       <= neg_in ? (~s_value + 32'd1) : s_value;
            bits_left_reg <= {1'b0, s_top_bit} + {{(STACK_CW-1){1'b0}}, 1'b1};
        end else if (cmd.push) begin
            val_reg       <= val_next;
            bits_left_reg <= bits_left_reg - {{(STACK_CW-1){1'b0}}, 1'b1};
        end
        if (cmd.mul) begin
            quot_reg <= prod[63:RECIP10_SHIFT];
        end
    end

    // Digit stack storage
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[sp_reg[STACK_AW-1:0]] <= digit;
        end
    end

    // Stack pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (cmd.load) begin
            sp_reg <= '0;
        end else if (cmd.push) begin
            sp_reg <= sp_reg + {{(STACK_CW-1){1'b0}}, 1'b1};
        end else if (cmd.emit_digit) begin
            sp_reg <= sp_dec;
        end
    end

    // Output register: load a character when free, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Pop the top of the stack straight into the output register
    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            char_reg <= CHR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= digit_char(stack_mem[sp_dec[STACK_AW-1:0]]);
            last_reg <= sts.last_pop;
        end
    end

    assign m_character = char_reg;
    assign m_last      = last_reg;
    assign m_valid     = valid_reg;

endmodule

// File: design/i2a_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for integer_to_ascii_digits.
// Depends on i2a_pkg; issues commands to i2a_datapath and reads its status.
module i2a_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  i2a_pkg::sts_t     sts,
    output i2a_pkg::cmd_t     cmd
);
    import i2a_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_req_type)
                        FMT_SDEC, FMT_UDEC:      state_next = ST_MUL;
                        FMT_HEX, FMT_OCT, FMT_BIN: state_next = ST_PUSH;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (sts.push_done) begin
                    state_next = sts.neg ? ST_SIGN : ST_EMIT;
                end else if (sts.is_dec) begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free && sts.last_pop) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = accept;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
            end
            ST_SIGN: begin
                cmd.emit_sign = sts.out_free;
            end
            ST_EMIT: begin
                cmd.emit_digit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
